/* rtl/keyed_saturating_counter_table_core_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the keyed counter table
// Implication checks, sampled on the rising clock edge, off during reset.
// ---------------------------------------------------------------------------
`ifndef KEYED_SATURATING_COUNTER_TABLE_CORE_ASSERT_SVH
`define KEYED_SATURATING_COUNTER_TABLE_CORE_ASSERT_SVH

// Same-cycle implication.
`define KCSCT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kcsct: same-cycle check failed");

// Next-cycle implication.
`define KCSCT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kcsct: next-cycle check failed");

`endif

/* rtl/kcsct_pkg.sv */
// ---------------------------------------------------------------------------
// kcsct_pkg
// Types and codes shared by the keyed counter table.
// ---------------------------------------------------------------------------
package kcsct_pkg;

    localparam int DEF_ENTRIES  = 32;
    localparam int DEF_KEY_BITS = 64;

    localparam int KEY_W    = 64;
    localparam int AMOUNT_W = 31;
    localparam int COUNT_W  = 32;

    // request codes
    localparam logic [1:0] REQ_ADD  = 2'd0;
    localparam logic [1:0] REQ_SUB  = 2'd1;
    localparam logic [1:0] REQ_LIST = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_ENTRY = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]          req_type;
        logic [KEY_W-1:0]    item_key;
        logic [AMOUNT_W-1:0] amount;
    } cmd_word_t;

    typedef struct packed {
        logic [1:0]         result_kind;
        logic [KEY_W-1:0]   entry_key;
        logic [COUNT_W-1:0] entry_count;
        logic               last;
    } result_word_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_UPDATE,
        ST_LIST
    } state_t;

endpackage

/* rtl/kcsct_ram.sv */
// ---------------------------------------------------------------------------
// kcsct_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module kcsct_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/keyed_saturating_counter_table_core.sv */
// ---------------------------------------------------------------------------
// keyed_saturating_counter_table_core
// Keyed saturating counters in insertion order, searched one entry a cycle.
// ---------------------------------------------------------------------------
// Add/subtract: the search walks the slots; a hit is written back in the update step,
// an add that misses appends the key, or gives a full word if the table is full.
// List: entries strobed in slot order, then an end marker (only the marker when empty).
// A new command is taken only while idle; the key/count RAMs have a single read port.
// Reset: entry count cleared at once, RAM contents left as they are, no sweep.
// Results are strobed for one cycle and cannot be stalled by the receiver.
// ---------------------------------------------------------------------------
`include "keyed_saturating_counter_table_core_assert.svh"

module keyed_saturating_counter_table_core #(
    parameter int ENTRIES  = kcsct_pkg::DEF_ENTRIES,
    parameter int KEY_BITS = kcsct_pkg::DEF_KEY_BITS
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  kcsct_pkg::cmd_word_t    cmd,
    output logic                    result_valid,
    output kcsct_pkg::result_word_t result
);

    // slot index and fill count widths
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CW    = kcsct_pkg::COUNT_W;
    localparam int AW    = kcsct_pkg::AMOUNT_W;

    // -----------------------------------------------------------------------
    // Registers
    // -----------------------------------------------------------------------
    kcsct_pkg::state_t       state_reg,        state_next;
    logic [1:0]              req_reg,          req_next;
    logic [KEY_BITS-1:0]     key_reg,          key_next;
    logic [AW-1:0]           amt_reg,          amt_next;
    logic [CNT_W-1:0]        scan_idx_reg,     scan_idx_next;
    logic                    pend_valid_reg,   pend_valid_next;
    logic [IDX_W-1:0]        pend_idx_reg,     pend_idx_next;
    logic [IDX_W-1:0]        hit_idx_reg,      hit_idx_next;
    logic [CW-1:0]           hit_count_reg,    hit_count_next;
    logic [CNT_W-1:0]        used_reg,         used_next;
    logic                    result_valid_reg, result_valid_next;
    kcsct_pkg::result_word_t result_reg,       result_next;

    // RAM ports
    logic                key_we;
    logic                count_we;
    logic [IDX_W-1:0]    count_waddr;
    logic [CW-1:0]       count_wdata;
    logic                rd_en;
    logic [KEY_BITS-1:0] key_rd;
    logic [CW-1:0]       count_rd;

    // search helpers
    logic          issue;      // another stored slot still to read
    logic          key_hit;    // slot read last cycle matches
    logic          scan_done;  // every slot read and compared
    logic [CW:0]   sum_wide;
    logic [CW-1:0] add_sat;
    logic [CW-1:0] sub_floor;

    assign busy         = (state_reg != kcsct_pkg::ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign issue     = (scan_idx_reg < used_reg);
    assign key_hit   = pend_valid_reg && (key_rd == key_reg);
    assign scan_done = !pend_valid_reg && !issue;

    // shared arithmetic, used only in the update step
    assign sum_wide  = {1'b0, hit_count_reg} + (CW + 1)'(amt_reg);
    assign add_sat   = sum_wide[CW] ? {CW{1'b1}} : sum_wide[CW-1:0];
    assign sub_floor = (hit_count_reg >= CW'(amt_reg)) ?
                       (hit_count_reg - CW'(amt_reg)) : '0;

    // -----------------------------------------------------------------------
    // Table storage: keys and counts, read together at the scan index
    // -----------------------------------------------------------------------
    kcsct_ram #(
        .WIDTH  (KEY_BITS),
        .DEPTH  (ENTRIES),
        .ADDR_W (IDX_W)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (used_reg[IDX_W-1:0]),
        .wdata (key_reg),
        .re    (rd_en),
        .raddr (scan_idx_reg[IDX_W-1:0]),
        .rdata (key_rd)
    );

    kcsct_ram #(
        .WIDTH  (CW),
        .DEPTH  (ENTRIES),
        .ADDR_W (IDX_W)
    ) u_count_ram (
        .clk   (clk),
        .we    (count_we),
        .waddr (count_waddr),
        .wdata (count_wdata),
        .re    (rd_en),
        .raddr (scan_idx_reg[IDX_W-1:0]),
        .rdata (count_rd)
    );

    // -----------------------------------------------------------------------
    // Next state
    // -----------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            kcsct_pkg::ST_IDLE:
            begin
                if (start && (cmd.req_type inside {kcsct_pkg::REQ_ADD, kcsct_pkg::REQ_SUB}))
                begin
                    state_next = kcsct_pkg::ST_SEARCH;
                end
                else if (start && (cmd.req_type == kcsct_pkg::REQ_LIST))
                begin
                    state_next = kcsct_pkg::ST_LIST;
                end
            end
            kcsct_pkg::ST_SEARCH:
            begin
                if (key_hit)
                begin
                    state_next = kcsct_pkg::ST_UPDATE;
                end
                else if (scan_done)
                begin
                    state_next = kcsct_pkg::ST_IDLE;
                end
            end
            kcsct_pkg::ST_UPDATE:
            begin
                state_next = kcsct_pkg::ST_IDLE;
            end
            kcsct_pkg::ST_LIST:
            begin
                if (!pend_valid_reg && !issue)
                begin
                    state_next = kcsct_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = kcsct_pkg::ST_IDLE;
            end
        endcase
    end

    // -----------------------------------------------------------------------
    // Datapath and outputs
    // -----------------------------------------------------------------------
    always_comb
    begin
        req_next          = req_reg;
        key_next          = key_reg;
        amt_next          = amt_reg;
        scan_idx_next     = scan_idx_reg;
        pend_valid_next   = 1'b0;
        pend_idx_next     = pend_idx_reg;
        hit_idx_next      = hit_idx_reg;
        hit_count_next    = hit_count_reg;
        used_next         = used_reg;
        result_valid_next = 1'b0;
        result_next       = result_reg;
        key_we            = 1'b0;
        count_we          = 1'b0;
        count_waddr       = used_reg[IDX_W-1:0];
        count_wdata       = CW'(amt_reg);
        rd_en             = 1'b0;

        case (state_reg)
            kcsct_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    req_next      = cmd.req_type;
                    key_next      = cmd.item_key[KEY_BITS-1:0];
                    amt_next      = cmd.amount;
                    scan_idx_next = '0;
                end
            end
            kcsct_pkg::ST_SEARCH:
            begin
                // read slot n while comparing slot n-1
                rd_en           = issue;
                pend_valid_next = issue;
                pend_idx_next   = scan_idx_reg[IDX_W-1:0];
                if (issue)
                begin
                    scan_idx_next = scan_idx_reg + CNT_W'(1);
                end
                if (key_hit)
                begin
                    hit_idx_next   = pend_idx_reg;
                    hit_count_next = count_rd;
                end
                else if (scan_done && (req_reg == kcsct_pkg::REQ_ADD))
                begin
                    if (used_reg < CNT_W'(ENTRIES))
                    begin
                        // append new key with the amount as its count
                        key_we    = 1'b1;
                        count_we  = 1'b1;
                        used_next = used_reg + CNT_W'(1);
                    end
                    else
                    begin
                        result_valid_next       = 1'b1;
                        result_next.result_kind = kcsct_pkg::KIND_FULL;
                        result_next.entry_key   = kcsct_pkg::KEY_W'(key_reg);
                        result_next.entry_count = '0;
                        result_next.last        = 1'b1;
                    end
                end
            end
            kcsct_pkg::ST_UPDATE:
            begin
                count_we    = 1'b1;
                count_waddr = hit_idx_reg;
                count_wdata = (req_reg == kcsct_pkg::REQ_ADD) ? add_sat : sub_floor;
            end
            kcsct_pkg::ST_LIST:
            begin
                rd_en           = issue;
                pend_valid_next = issue;
                if (issue)
                begin
                    scan_idx_next = scan_idx_reg + CNT_W'(1);
                end
                if (pend_valid_reg)
                begin
                    result_valid_next       = 1'b1;
                    result_next.result_kind = kcsct_pkg::KIND_ENTRY;
                    result_next.entry_key   = kcsct_pkg::KEY_W'(key_rd);
                    result_next.entry_count = count_rd;
                    result_next.last        = 1'b0;
                end
                else if (!issue)
                begin
                    result_valid_next       = 1'b1;
                    result_next.result_kind = kcsct_pkg::KIND_END;
                    result_next.entry_key   = '0;
                    result_next.entry_count = '0;
                    result_next.last        = 1'b1;
                end
            end
            default:
            begin
                pend_valid_next = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= kcsct_pkg::ST_IDLE;
            pend_valid_reg   <= 1'b0;
            used_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            pend_valid_reg   <= pend_valid_next;
            used_reg         <= used_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        key_reg       <= key_next;
        amt_reg       <= amt_next;
        scan_idx_reg  <= scan_idx_next;
        pend_idx_reg  <= pend_idx_next;
        hit_idx_reg   <= hit_idx_next;
        hit_count_reg <= hit_count_next;
        result_reg    <= result_next;
    end

    // -----------------------------------------------------------------------
    // Checks
    // -----------------------------------------------------------------------
    `KCSCT_ASSERT_NOW(a_used_in_range, clk, rst_n, 1'b1, used_reg <= CNT_W'(ENTRIES))
    `KCSCT_ASSERT_NOW(a_full_only_when_full, clk, rst_n, result_valid && (result.result_kind == kcsct_pkg::KIND_FULL), used_reg == CNT_W'(ENTRIES))
    `KCSCT_ASSERT_NOW(a_last_frees_block, clk, rst_n, result_valid, result.last == !busy)
    `KCSCT_ASSERT_NEXT(a_update_returns_idle, clk, rst_n, state_reg == kcsct_pkg::ST_UPDATE, !busy)

endmodule
